FILE: rtl/dtu_pkg.sv
`default_nettype none

package dtu_pkg;

    // Widths of the transferred fields.
    localparam int YearW   = 7;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;
    localparam int ZoneW   = 7;
    localparam int SecsW   = 32;

    // Widths of the internal values.
    localparam int DaysW   = 16;
    localparam int SodW    = 17;
    localparam int OffW    = 17;

    // Limits of the input fields.
    localparam logic [MonthW-1:0]  MonthMax  = 4'd12;
    localparam logic [HourW-1:0]   HourMax   = 5'd23;
    localparam logic [MinuteW-1:0] MinuteMax = 6'd59;
    localparam logic [SecondW-1:0] SecondMax = 6'd60;
    localparam logic [ZoneW-1:0]   ZoneMax   = 7'd96;

    // Calendar constants.
    localparam logic [DaysW-1:0] DaysEpochTo2000 = 16'd10957;
    localparam logic [SecsW-1:0] SecsPerDay      = 32'd86400;
    localparam logic [YearW-1:0] MinYearReset    = 7'd25;
    localparam logic [YearW-1:0] Year2100        = 7'd100;

    // One input item.
    typedef struct packed {
        logic [YearW-1:0]   year_two_digit;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
        logic               zone_negative;
        logic [ZoneW-1:0]   zone_quarter_hours;
    } t_in_item;

    // Values passed from the day count stage to the seconds stage.
    typedef struct packed {
        logic             ok;
        logic [DaysW-1:0] days;
        logic [SodW-1:0]  sod;
        logic             neg;
        logic [OffW-1:0]  off;
    } t_mid;

    // True when year 2000 + yy is a leap year; 2100 is the only century year in the range that is not one.
    function automatic logic is_leap(input logic [YearW-1:0] yy);
        return (yy[1:0] == 2'd0) && (yy != Year2100);
    endfunction

    // Days from 2000-01-01 to the first day of year 2000 + yy.
    function automatic logic [DaysW-1:0] days_before_year(input logic [YearW-1:0] yy);
        logic [DaysW-1:0] base;
        logic [DaysW-1:0] leaps;
        base  = DaysW'(yy) * 16'd365;
        leaps = DaysW'((8'(yy) + 8'd3) >> 2);
        if (yy > Year2100) begin
            leaps = leaps - 16'd1;
        end
        return base + leaps;
    endfunction

    // Days from January 1 to the first day of the month, leap day included.
    function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] mon,
                                                     input logic leap);
        logic [8:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (mon > 4'd2)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dtu_in_if.sv
`default_nettype none

// Input channel: one parsed local date and time per transfer.
interface dtu_in_if;
    logic                          valid;
    logic                          ready;
    logic [dtu_pkg::YearW-1:0]     year_two_digit;
    logic [dtu_pkg::MonthW-1:0]    month;
    logic [dtu_pkg::DayW-1:0]      day;
    logic [dtu_pkg::HourW-1:0]     hour;
    logic [dtu_pkg::MinuteW-1:0]   minute;
    logic [dtu_pkg::SecondW-1:0]   second;
    logic                          zone_negative;
    logic [dtu_pkg::ZoneW-1:0]     zone_quarter_hours;

    modport source (
        output valid, year_two_digit, month, day, hour, minute, second,
               zone_negative, zone_quarter_hours,
        input  ready
    );
    modport sink (
        input  valid, year_two_digit, month, day, hour, minute, second,
               zone_negative, zone_quarter_hours,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/dtu_out_if.sv
`default_nettype none

// Result channel: seconds since the epoch and a valid flag per transfer.
interface dtu_out_if;
    logic                        valid;
    logic                        ready;
    logic [dtu_pkg::SecsW-1:0]   unix_seconds;
    logic                        time_valid;

    modport source (
        output valid, unix_seconds, time_valid,
        input  ready
    );
    modport sink (
        input  valid, unix_seconds, time_valid,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/dtu_cfg_if.sv
`default_nettype none

// Configuration channel: write data for the minimum year register.
interface dtu_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dtu_pkg::YearW-1:0]   data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/dtu_days.sv
`default_nettype none

// Input register, range checks, day count and seconds of day.
module dtu_days (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    dtu_in_if.sink             i_data,
    input  wire logic [dtu_pkg::YearW-1:0] i_min_year,
    output logic               o_mid_valid,
    input  wire logic          i_mid_ready,
    output dtu_pkg::t_mid      o_mid
);

    logic              r_in_valid;
    dtu_pkg::t_in_item r_in;
    logic              w_in_ready;
    logic              w_in_take;

    dtu_pkg::t_mid     n_mid;

    logic              w_leap;
    logic [8:0]        w_month_days;

    // The input register takes a new item when it is empty or its content moves on.
    assign w_in_ready = !r_in_valid || i_mid_ready;
    assign w_in_take  = i_data.valid && w_in_ready;

    assign i_data.ready = w_in_ready;
    assign o_mid_valid  = r_in_valid;
    assign o_mid        = n_mid;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_data.valid;
        end
        if (w_in_take) begin
            r_in.year_two_digit     <= i_data.year_two_digit;
            r_in.month              <= i_data.month;
            r_in.day                <= i_data.day;
            r_in.hour               <= i_data.hour;
            r_in.minute             <= i_data.minute;
            r_in.second             <= i_data.second;
            r_in.zone_negative      <= i_data.zone_negative;
            r_in.zone_quarter_hours <= i_data.zone_quarter_hours;
        end
    end

    // Range checks, days since the epoch, seconds into the day and zone offset.
    always_comb begin
        w_leap       = dtu_pkg::is_leap(r_in.year_two_digit);
        w_month_days = dtu_pkg::days_before_month(r_in.month, w_leap);

        n_mid.ok = (r_in.year_two_digit >= i_min_year)
                && (r_in.month != 4'd0) && (r_in.month <= dtu_pkg::MonthMax)
                && (r_in.day != 5'd0)
                && (r_in.hour <= dtu_pkg::HourMax)
                && (r_in.minute <= dtu_pkg::MinuteMax)
                && (r_in.second <= dtu_pkg::SecondMax)
                && (r_in.zone_quarter_hours <= dtu_pkg::ZoneMax);

        n_mid.days = dtu_pkg::DaysEpochTo2000
                   + dtu_pkg::days_before_year(r_in.year_two_digit)
                   + dtu_pkg::DaysW'(w_month_days)
                   + dtu_pkg::DaysW'(r_in.day) - 16'd1;

        n_mid.sod = dtu_pkg::SodW'(r_in.hour) * 17'd3600
                  + dtu_pkg::SodW'(r_in.minute) * 17'd60
                  + dtu_pkg::SodW'(r_in.second);

        n_mid.neg = r_in.zone_negative;
        n_mid.off = dtu_pkg::OffW'(r_in.zone_quarter_hours) * 17'd900;
    end

endmodule

`default_nettype wire

FILE: rtl/dtu_secs.sv
`default_nettype none

// Days times seconds per day, time of day, zone correction and result register.
module dtu_secs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_mid_valid,
    output logic               o_mid_ready,
    input  wire dtu_pkg::t_mid i_mid,
    dtu_out_if.source          o_result
);

    logic                      r_out_valid;
    logic [dtu_pkg::SecsW-1:0] r_secs;
    logic                      r_ok;
    logic                      w_room;
    logic [dtu_pkg::SecsW-1:0] w_base;
    logic [dtu_pkg::SecsW-1:0] w_off;
    logic [dtu_pkg::SecsW-1:0] n_secs;

    assign w_room      = !r_out_valid || o_result.ready;
    assign o_mid_ready = w_room;

    // Seconds count, wrapping in 32 bits, then the zone correction; an item that fails the checks gives zero.
    always_comb begin
        w_base = dtu_pkg::SecsW'(i_mid.days) * dtu_pkg::SecsPerDay
               + dtu_pkg::SecsW'(i_mid.sod);
        w_off  = dtu_pkg::SecsW'(i_mid.off);
        if (!i_mid.ok) begin
            n_secs = '0;
        end else if (i_mid.neg) begin
            n_secs = w_base + w_off;
        end else begin
            n_secs = w_base - w_off;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_room) begin
            r_out_valid <= i_mid_valid;
        end
        if (w_room && i_mid_valid) begin
            r_secs <= n_secs;
            r_ok   <= i_mid.ok;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.unix_seconds = r_secs;
    assign o_result.time_valid   = r_ok;

endmodule

`default_nettype wire

FILE: rtl/date_time_to_unix_seconds.sv
// A result passes through the input register and then the result register before it is offered.
// Throughput: one item per cycle while results are taken; checks, day count, the 16 by 32 bit
// multiply and the zone correction form one combinational pass between the input and the result
// register. Each register moves on when the next one is empty or its content is taken.
// Reset (synchronous, active low) empties both registers and sets the minimum year to 25.
// Configuration writes are taken in any cycle.
`default_nettype none

module date_time_to_unix_seconds (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtu_cfg_if.sink   i_cfg,
    dtu_in_if.sink    i_data,
    dtu_out_if.source o_result
);

    logic [dtu_pkg::YearW-1:0] r_min_year;
    logic                      w_mid_valid;
    logic                      w_mid_ready;
    dtu_pkg::t_mid             w_mid;

    // Minimum year register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= dtu_pkg::MinYearReset;
        end else if (i_cfg.valid) begin
            r_min_year <= i_cfg.data;
        end
    end

    // Input register and day count.
    dtu_days u_days (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_min_year  (r_min_year),
        .o_mid_valid (w_mid_valid),
        .i_mid_ready (w_mid_ready),
        .o_mid       (w_mid)
    );

    // Seconds count and result register.
    dtu_secs u_secs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (w_mid_valid),
        .o_mid_ready (w_mid_ready),
        .i_mid       (w_mid),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

FILE: tb/date_time_to_unix_seconds_tb.sv
module date_time_to_unix_seconds_tb;

    localparam int QuietLimit  = 2000;
    localparam int DrainCycles = 10;
    localparam int PhaseItems  = 165;
    localparam int PhaseCount  = 6;
    localparam int HoldCycles  = 120;

    // One expected result: seconds since the epoch and the valid flag.
    typedef struct packed {
        logic [dtu_pkg::SecsW-1:0] secs;
        logic                      ok;
    } t_stamp;

    // One row of the directed table.
    typedef struct {
        dtu_pkg::t_in_item item;
        bit                known;
        t_stamp            stamp;
    } t_row;

    // Which field a broken item puts out of range.
    typedef enum {FLAW_MONTH, FLAW_DAY, FLAW_HOUR, FLAW_MINUTE, FLAW_SECOND, FLAW_ZONE} t_flaw;

    logic i_clk;
    logic i_rst_n;

    dtu_cfg_if cfg_ch();
    dtu_in_if  date_ch();
    dtu_out_if stamp_ch();

    logic [dtu_pkg::YearW-1:0] min_year = dtu_pkg::MinYearReset;
    t_stamp                    pending_stamps[$];
    t_row                      directed_rows[$];
    int                        errors = 0;
    int                        hold_requests = 0;
    bit                        send_gaps = 1'b1;
    bit                        recv_gaps = 1'b1;

    date_time_to_unix_seconds u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_data  (date_ch),
        .o_result(stamp_ch)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Full Gregorian leap rule.
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned m);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return 28;
            default:     return 31;
        endcase
    endfunction

    // Expected conversion of one date under the given minimum year.
    function automatic t_stamp predict_stamp(input dtu_pkg::t_in_item it,
                                             input logic [dtu_pkg::YearW-1:0] min_yr);
        t_stamp      st;
        int unsigned year;
        int unsigned days;
        int unsigned secs;
        int unsigned zone_secs;
        int unsigned k;
        st = '0;
        if (it.year_two_digit < min_yr || it.month == 0 || it.month > dtu_pkg::MonthMax ||
            it.day == 0 || it.hour > dtu_pkg::HourMax || it.minute > dtu_pkg::MinuteMax ||
            it.second > dtu_pkg::SecondMax || it.zone_quarter_hours > dtu_pkg::ZoneMax) begin
            return st;
        end
        year = 2000 + it.year_two_digit;
        days = 0;
        for (k = 1970; k < year; k++) begin
            days += leap_year(k) ? 366 : 365;
        end
        for (k = 1; k < it.month; k++) begin
            days += month_length(k);
            if (k == 2 && leap_year(year)) begin
                days++;
            end
        end
        days += it.day - 32'd1;
        secs = days * 32'd86400 + it.hour * 32'd3600 + it.minute * 32'd60 + it.second;
        zone_secs = it.zone_quarter_hours * 32'd900;
        // The zone is removed to reach UTC; both directions wrap in 32 bits.
        secs = it.zone_negative ? secs + zone_secs : secs - zone_secs;
        st.secs = secs;
        st.ok   = 1'b1;
        return st;
    endfunction

    function automatic dtu_pkg::t_in_item make_date(input int y, mo, d, h, mi, s, neg, qh);
        dtu_pkg::t_in_item it;
        it.year_two_digit     = dtu_pkg::YearW'(y);
        it.month              = dtu_pkg::MonthW'(mo);
        it.day                = dtu_pkg::DayW'(d);
        it.hour               = dtu_pkg::HourW'(h);
        it.minute             = dtu_pkg::MinuteW'(mi);
        it.second             = dtu_pkg::SecondW'(s);
        it.zone_negative      = 1'(neg);
        it.zone_quarter_hours = dtu_pkg::ZoneW'(qh);
        return it;
    endfunction

    // Mostly well-formed dates, some with one field out of range, some pure noise.
    function automatic dtu_pkg::t_in_item random_date(input logic [dtu_pkg::YearW-1:0] min_yr);
        dtu_pkg::t_in_item it;
        logic [63:0]       raw;
        int unsigned       pick;
        int unsigned       lo;
        t_flaw             flaw;
        pick = $urandom_range(9, 0);
        if (pick == 0) begin
            raw = {$urandom, $urandom};
            it  = raw[$bits(dtu_pkg::t_in_item)-1:0];
            return it;
        end
        lo = (min_yr > 7'd99) ? 99 : 32'(min_yr);
        it.year_two_digit     = ($urandom_range(7, 0) == 0)
                              ? dtu_pkg::YearW'($urandom_range(127, 0))
                              : dtu_pkg::YearW'($urandom_range(99, lo));
        it.month              = dtu_pkg::MonthW'($urandom_range(12, 1));
        it.day                = dtu_pkg::DayW'($urandom_range(31, 1));
        it.hour               = dtu_pkg::HourW'($urandom_range(23, 0));
        it.minute             = dtu_pkg::MinuteW'($urandom_range(59, 0));
        it.second             = dtu_pkg::SecondW'($urandom_range(60, 0));
        it.zone_negative      = 1'($urandom_range(1, 0));
        it.zone_quarter_hours = dtu_pkg::ZoneW'($urandom_range(96, 0));
        if (pick == 1) begin
            flaw = t_flaw'($urandom_range(5, 0));
            case (flaw)
                FLAW_MONTH:  it.month = ($urandom_range(1, 0) != 0)
                                      ? 4'd0 : dtu_pkg::MonthW'($urandom_range(15, 13));
                FLAW_DAY:    it.day = 5'd0;
                FLAW_HOUR:   it.hour = dtu_pkg::HourW'($urandom_range(31, 24));
                FLAW_MINUTE: it.minute = dtu_pkg::MinuteW'($urandom_range(63, 60));
                FLAW_SECOND: it.second = dtu_pkg::SecondW'($urandom_range(63, 61));
                default:     it.zone_quarter_hours = dtu_pkg::ZoneW'($urandom_range(127, 97));
            endcase
        end
        return it;
    endfunction

    task automatic add_known(input int y, mo, d, h, mi, s, neg, qh,
                             input int unsigned secs, input bit ok);
        t_row row;
        row.item       = make_date(y, mo, d, h, mi, s, neg, qh);
        row.known      = 1'b1;
        row.stamp.secs = secs;
        row.stamp.ok   = ok;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked(input int y, mo, d, h, mi, s, neg, qh);
        t_row row;
        row.item  = make_date(y, mo, d, h, mi, s, neg, qh);
        row.known = 1'b0;
        row.stamp = '0;
        directed_rows.push_back(row);
    endtask

    // Offers one date, with an optional gap first, and records its expected result.
    task automatic send_date(input dtu_pkg::t_in_item it, input t_stamp st);
        int gap;
        if (send_gaps && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(7, 1);
            repeat (gap) begin
                @(negedge i_clk);
                date_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        date_ch.valid              <= 1'b1;
        date_ch.year_two_digit     <= it.year_two_digit;
        date_ch.month              <= it.month;
        date_ch.day                <= it.day;
        date_ch.hour               <= it.hour;
        date_ch.minute             <= it.minute;
        date_ch.second             <= it.second;
        date_ch.zone_negative      <= it.zone_negative;
        date_ch.zone_quarter_hours <= it.zone_quarter_hours;
        do @(posedge i_clk); while (!date_ch.ready);
        pending_stamps.push_back(st);
    endtask

    // Stops offering dates and waits until every result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        date_ch.valid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_min_year(input logic [dtu_pkg::YearW-1:0] v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        min_year = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stall bursts, plus a long hold-off when requested.
    initial begin : result_sink
        int stall;
        int hold_left;
        int hold_seen;
        stall     = 0;
        hold_left = 0;
        hold_seen = 0;
        stamp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                stamp_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                stamp_ch.ready <= 1'b0;
            end else if (recv_gaps && $urandom_range(4, 0) == 0) begin
                stall = $urandom_range(6, 0);
                stamp_ch.ready <= 1'b0;
            end else begin
                stamp_ch.ready <= 1'b1;
            end
        end
    end

    // Each result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_stamp want;
        if (i_rst_n && stamp_ch.valid && stamp_ch.ready) begin
            if (pending_stamps.size() == 0) begin
                $display("%0t: unexpected result, unix_seconds %0d time_valid %0b",
                         $time, stamp_ch.unix_seconds, stamp_ch.time_valid);
                errors++;
            end else begin
                want = pending_stamps.pop_front();
                if (stamp_ch.unix_seconds !== want.secs) begin
                    $display("%0t: unix_seconds expected %0d actual %0d",
                             $time, want.secs, stamp_ch.unix_seconds);
                    errors++;
                end
                if (stamp_ch.time_valid !== want.ok) begin
                    $display("%0t: time_valid expected %0b actual %0b",
                             $time, want.ok, stamp_ch.time_valid);
                    errors++;
                end
            end
        end
    end

    // Ends the run when no transfer happens on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if ((date_ch.valid && date_ch.ready) || (stamp_ch.valid && stamp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        dtu_pkg::t_in_item         it;
        logic [dtu_pkg::YearW-1:0] phase_min;
        int                        phase;
        int                        n;
        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        it           = '0;
        date_ch.valid              = 1'b0;
        date_ch.year_two_digit     = it.year_two_digit;
        date_ch.month              = it.month;
        date_ch.day                = it.day;
        date_ch.hour               = it.hour;
        date_ch.minute             = it.minute;
        date_ch.second             = it.second;
        date_ch.zone_negative      = it.zone_negative;
        date_ch.zone_quarter_hours = it.zone_quarter_hours;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, run with the minimum year left at its reset value.
        //        year mon day hr  min sec neg zone
        add_known(24,  1,  1,  0,  0,  0,  0,  0,  0, 1'b0);           // year below minimum
        add_known(25,  1,  1,  0,  0,  0,  0,  0,  1735689600, 1'b1);  // 2025-01-01 UTC
        add_known(25,  0,  1,  0,  0,  0,  0,  0,  0, 1'b0);
        add_known(25,  13, 1,  0,  0,  0,  0,  0,  0, 1'b0);
        add_known(99,  15, 31, 23, 59, 59, 1,  96, 0, 1'b0);
        add_known(25,  6,  0,  12, 0,  0,  0,  0,  0, 1'b0);
        add_known(30,  6,  15, 24, 0,  0,  0,  0,  0, 1'b0);
        add_known(30,  6,  15, 31, 0,  0,  1,  8,  0, 1'b0);
        add_known(40,  7,  4,  9,  60, 0,  0,  0,  0, 1'b0);
        add_known(40,  7,  4,  9,  63, 0,  0,  0,  0, 1'b0);
        add_known(50,  8,  8,  8,  8,  61, 0,  0,  0, 1'b0);
        add_known(50,  8,  8,  8,  8,  63, 1,  4,  0, 1'b0);
        add_known(60,  9,  9,  9,  9,  9,  0,  97, 0, 1'b0);
        add_known(60,  9,  9,  9,  9,  9,  1,  127, 0, 1'b0);
        add_checked(25, 12, 31, 23, 59, 60, 0, 0);     // leap second
        add_checked(28, 2,  29, 12, 0,  0,  1, 4);     // leap day
        add_checked(25, 2,  30, 0,  0,  0,  0, 0);     // day past the end of February
        add_checked(26, 4,  31, 6,  30, 0,  0, 38);
        add_checked(99, 12, 31, 23, 59, 59, 0, 96);
        add_checked(100, 3, 1,  0,  0,  0,  0, 0);     // 2100 has no leap day
        add_checked(104, 3, 1,  0,  0,  0,  1, 96);
        add_checked(127, 12, 31, 23, 59, 60, 1, 96);   // count wraps past 32 bits
        add_checked(106, 2, 7,  6,  28, 16, 0, 1);     // zone pulls below zero
        add_checked(106, 2, 7,  6,  20, 0,  1, 96);    // zone pushes past the top
        add_checked(50,  6, 15, 0,  0,  0,  1, 0);
        foreach (directed_rows[i]) begin
            send_date(directed_rows[i].item,
                      directed_rows[i].known ? directed_rows[i].stamp
                                             : predict_stamp(directed_rows[i].item, min_year));
        end
        drain_results();

        // Random phases, each under its own minimum year.
        for (phase = 0; phase < PhaseCount; phase++) begin
            case (phase)
                0:       phase_min = '0;
                1:       phase_min = '1;
                2:       phase_min = 7'd99;
                3:       phase_min = dtu_pkg::YearW'($urandom_range(99, 0));
                4:       phase_min = 7'd100;
                default: phase_min = dtu_pkg::MinYearReset;
            endcase
            write_min_year(phase_min);
            // The result side holds off while dates keep coming, so the pipeline backs up.
            if (phase == 1) begin
                hold_requests++;
            end
            // The last phase runs at full rate on both sides.
            if (phase == PhaseCount - 1) begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            for (n = 0; n < PhaseItems; n++) begin
                if (phase == 2 && n == PhaseItems / 2) begin
                    drain_results();
                end
                it = random_date(min_year);
                send_date(it, predict_stamp(it, min_year));
            end
            drain_results();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
